// ===== sv/next_fit_buffer_pool_allocator_assert.svh =====
// Assertion macros used by the allocator top level.
`ifndef NEXT_FIT_BUFFER_POOL_ALLOCATOR_ASSERT_SVH
`define NEXT_FIT_BUFFER_POOL_ALLOCATOR_ASSERT_SVH

// A property that must hold in the same cycle as its antecedent.
`define NFBPA_CHECK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A property that must hold in the cycle after its antecedent.
`define NFBPA_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/nfbpa_pkg.sv =====
`timescale 1ns / 1ps

package nfbpa_pkg;

    localparam int INDEX_W = 6;
    localparam int COUNT_W = 32;
    localparam int POOL_W  = 7;

    localparam logic [POOL_W-1:0] POOL_RESET = 7'd64;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

    typedef struct packed {
        t_action            action;
        logic [INDEX_W-1:0] index;
        logic               idx_ok;
    } t_cmd;

endpackage

// ===== sv/nfbpa_if.sv =====
`timescale 1ns / 1ps

interface nfbpa_req_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [nfbpa_pkg::INDEX_W-1:0] buffer_index;

    modport source (output valid, output action, output buffer_index, input ready);
    modport sink   (input valid, input action, input buffer_index, output ready);
endinterface

interface nfbpa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [nfbpa_pkg::INDEX_W-1:0] granted_index;
    logic [nfbpa_pkg::COUNT_W-1:0] alloc_count;
    logic [nfbpa_pkg::COUNT_W-1:0] free_count;
    logic [nfbpa_pkg::COUNT_W-1:0] error_count;

    modport source (output valid, output ok, output granted_index, output alloc_count,
                    output free_count, output error_count, input ready);
    modport sink   (input valid, input ok, input granted_index, input alloc_count,
                    input free_count, input error_count, output ready);
endinterface

// ===== sv/nfbpa_front.sv =====
`timescale 1ns / 1ps

module nfbpa_front (
    nfbpa_req_if.sink                   i_req,
    input  logic [nfbpa_pkg::POOL_W-1:0] i_eff_size,
    input  logic                        i_q_full,
    output logic                        o_push,
    output nfbpa_pkg::t_cmd             o_cmd
);

    assign i_req.ready = !i_q_full;
    assign o_push      = i_req.valid && !i_q_full;

    always_comb begin
        o_cmd.action = nfbpa_pkg::t_action'(i_req.action);
        o_cmd.index  = i_req.buffer_index;
        // A free is only honored for a buffer inside the pool in use.
        o_cmd.idx_ok = (nfbpa_pkg::POOL_W'(i_req.buffer_index) < i_eff_size);
    end

endmodule

// ===== sv/nfbpa_fifo.sv =====
`timescale 1ns / 1ps

module nfbpa_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  nfbpa_pkg::t_cmd i_data,
    input  logic            i_pop,
    output logic            o_valid,
    output logic            o_full,
    output nfbpa_pkg::t_cmd o_data
);

    localparam int DEPTH = 2;

    nfbpa_pkg::t_cmd r_mem [DEPTH];
    logic            r_wptr;
    logic            r_rptr;
    logic [1:0]      r_count;
    logic [1:0]      n_count;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'(DEPTH));
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ===== sv/nfbpa_back.sv =====
`timescale 1ns / 1ps

module nfbpa_back #(
    parameter int NUM_FLAGS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [nfbpa_pkg::POOL_W-1:0] i_eff_size,
    input  logic                         i_q_valid,
    input  nfbpa_pkg::t_cmd              i_q_data,
    output logic                         o_pop,
    nfbpa_rsp_if.source                  o_rsp
);

    localparam int IW = $clog2(NUM_FLAGS);

    logic [NUM_FLAGS-1:0]          r_in_use;
    logic [NUM_FLAGS-1:0]          n_in_use;
    logic [IW-1:0]                 r_search;
    logic [IW-1:0]                 n_search;
    logic [nfbpa_pkg::COUNT_W-1:0] r_allocs;
    logic [nfbpa_pkg::COUNT_W-1:0] n_allocs;
    logic [nfbpa_pkg::COUNT_W-1:0] r_frees;
    logic [nfbpa_pkg::COUNT_W-1:0] n_frees;
    logic [nfbpa_pkg::COUNT_W-1:0] r_errors;
    logic [nfbpa_pkg::COUNT_W-1:0] n_errors;
    logic                          r_out_valid;
    logic                          r_ok;
    logic                          n_ok;
    logic [nfbpa_pkg::INDEX_W-1:0] r_granted;
    logic [nfbpa_pkg::INDEX_W-1:0] n_granted;

    logic [NUM_FLAGS-1:0] w_size_mask;
    logic [NUM_FLAGS-1:0] w_upper_mask;
    logic [NUM_FLAGS-1:0] w_free_vec;
    logic [NUM_FLAGS-1:0] w_pick_vec;
    logic [NUM_FLAGS-1:0] w_first;
    logic [IW-1:0]        w_start;
    logic [IW-1:0]        w_found_idx;
    logic [IW-1:0]        w_free_idx;
    logic                 w_found;

    assign o_pop     = i_q_valid && (!r_out_valid || o_rsp.ready);
    assign w_start   = (8'(r_search) < 8'(i_eff_size)) ? r_search : '0;
    assign w_free_idx = IW'(i_q_data.index);

    // Next-fit search: the lowest free buffer at or above the start wins,
    // otherwise the lowest free buffer of the whole pool.
    always_comb begin
        w_found_idx = '0;
        for (int i = 0; i < NUM_FLAGS; i++) begin
            w_size_mask[i]  = (i < int'(i_eff_size));
            w_upper_mask[i] = (i >= int'(w_start));
        end
        w_free_vec = ~r_in_use & w_size_mask;
        w_found    = |w_free_vec;
        w_pick_vec = (|(w_free_vec & w_upper_mask)) ? (w_free_vec & w_upper_mask)
                                                     : w_free_vec;
        w_first    = w_pick_vec & (~w_pick_vec + NUM_FLAGS'(1));
        for (int i = 0; i < NUM_FLAGS; i++) begin
            if (w_first[i]) begin
                w_found_idx = w_found_idx | IW'(i);
            end
        end
    end

    always_comb begin
        n_in_use  = r_in_use;
        n_search  = r_search;
        n_allocs  = r_allocs;
        n_frees   = r_frees;
        n_errors  = r_errors;
        n_ok      = 1'b0;
        n_granted = '0;
        case (i_q_data.action)
            nfbpa_pkg::ACT_ALLOC: begin
                if (w_found) begin
                    n_in_use[w_found_idx] = 1'b1;
                    n_search              = w_found_idx;
                    n_allocs              = r_allocs + 32'd1;
                    n_ok                  = 1'b1;
                    n_granted             = nfbpa_pkg::INDEX_W'(w_found_idx);
                end else begin
                    n_errors = r_errors + 32'd1;
                end
            end
            nfbpa_pkg::ACT_FREE: begin
                if (i_q_data.idx_ok) begin
                    n_in_use[w_free_idx] = 1'b0;
                    n_ok                 = 1'b1;
                end
                n_frees = r_frees + 32'd1;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use    <= '0;
            r_search    <= '0;
            r_allocs    <= '0;
            r_frees     <= '0;
            r_errors    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_in_use    <= n_in_use;
                r_search    <= n_search;
                r_allocs    <= n_allocs;
                r_frees     <= n_frees;
                r_errors    <= n_errors;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ok      <= n_ok;
            r_granted <= n_granted;
        end
    end

    // The counters only move when a new result is loaded, so they always
    // match the result on display.
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.ok            = r_ok;
    assign o_rsp.granted_index = r_granted;
    assign o_rsp.alloc_count   = r_allocs;
    assign o_rsp.free_count    = r_frees;
    assign o_rsp.error_count   = r_errors;

endmodule

// ===== sv/next_fit_buffer_pool_allocator.sv =====
// Next-fit buffer pool allocator. Each request either allocates a buffer or
// frees one, and returns exactly one result with the granted index and the
// allocation, free and error counters after the update. Requests enter a
// two-entry queue and are executed in the back end, where a rotating
// find-first over the used-flag vector settles one request per cycle while
// the result register is free, and the result is then registered. The
// sustained rate is one request per cycle while the receiver accepts every
// result. While the receiver holds off, the queue and the result register
// hold three requests before the input stalls. All flags clear at reset,
// with no clearing pass. The pool size register may only be written while
// the block has no request in flight.
`timescale 1ns / 1ps

`include "next_fit_buffer_pool_allocator_assert.svh"

module next_fit_buffer_pool_allocator #(
    parameter int MAX_BUFFERS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [nfbpa_pkg::POOL_W-1:0] i_cfg_wdata,
    nfbpa_req_if.sink                    i_req,
    nfbpa_rsp_if.source                  o_rsp
);

    // The pool size register can name at most 127 buffers.
    localparam int POOL_MAX  = (1 << nfbpa_pkg::POOL_W) - 1;
    localparam int NUM_FLAGS = (MAX_BUFFERS < POOL_MAX) ? MAX_BUFFERS : POOL_MAX;

    logic [nfbpa_pkg::POOL_W-1:0] r_pool_size;
    logic [nfbpa_pkg::POOL_W-1:0] w_eff_size;
    logic                         w_push;
    logic                         w_pop;
    logic                         w_q_valid;
    logic                         w_q_full;
    nfbpa_pkg::t_cmd              w_cmd_in;
    nfbpa_pkg::t_cmd              w_cmd_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size <= nfbpa_pkg::POOL_RESET;
        end else if (i_cfg_we) begin
            r_pool_size <= i_cfg_wdata;
        end
    end

    assign w_eff_size = (r_pool_size > nfbpa_pkg::POOL_W'(NUM_FLAGS))
                      ? nfbpa_pkg::POOL_W'(NUM_FLAGS) : r_pool_size;

    nfbpa_front u_front (
        .i_req      (i_req),
        .i_eff_size (w_eff_size),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_cmd      (w_cmd_in)
    );

    nfbpa_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd_in),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_data  (w_cmd_out)
    );

    nfbpa_back #(
        .NUM_FLAGS (NUM_FLAGS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_eff_size (w_eff_size),
        .i_q_valid  (w_q_valid),
        .i_q_data   (w_cmd_out),
        .o_pop      (w_pop),
        .o_rsp      (o_rsp)
    );

    `NFBPA_CHECK_NOW(a_fail_no_index, o_rsp.valid && !o_rsp.ok, o_rsp.granted_index == 6'd0, "failed request carries an index")
    `NFBPA_CHECK_NEXT(a_push_queued, w_push, w_q_valid, "accepted request missing from queue")
    `NFBPA_CHECK_NEXT(a_pop_result, w_pop, o_rsp.valid, "executed request produced no result")

endmodule

// ===== sim/tb_next_fit_buffer_pool_allocator.sv =====
`timescale 1ns / 1ps

module tb_next_fit_buffer_pool_allocator;

    localparam int POOL_DEPTH = 64;

    typedef struct packed {
        logic                          ok;
        logic [nfbpa_pkg::INDEX_W-1:0] granted_index;
        logic [nfbpa_pkg::COUNT_W-1:0] alloc_count;
        logic [nfbpa_pkg::COUNT_W-1:0] free_count;
        logic [nfbpa_pkg::COUNT_W-1:0] error_count;
    } t_pool_result;

    class t_pool_tracker;
        bit                            used_flag [POOL_DEPTH];
        logic [nfbpa_pkg::INDEX_W-1:0] next_fit_from;
        logic [nfbpa_pkg::COUNT_W-1:0] allocs;
        logic [nfbpa_pkg::COUNT_W-1:0] frees;
        logic [nfbpa_pkg::COUNT_W-1:0] failures;
        logic [nfbpa_pkg::POOL_W-1:0]  pool_size;
        t_pool_result                  expected_results [$];
        int                            mismatches;
        int                            results_seen;

        function new();
            foreach (used_flag[i]) used_flag[i] = 1'b0;
            next_fit_from = '0;
            allocs        = '0;
            frees         = '0;
            failures      = '0;
            pool_size     = nfbpa_pkg::POOL_RESET;
            mismatches    = 0;
            results_seen  = 0;
        endfunction

        function void set_pool_size(logic [nfbpa_pkg::POOL_W-1:0] value);
            pool_size = value;
        endfunction

        function int unsigned buffers_in_use();
            return (pool_size > POOL_DEPTH) ? POOL_DEPTH : pool_size;
        endfunction

        function void take_request(nfbpa_pkg::t_action act,
                                   logic [nfbpa_pkg::INDEX_W-1:0] idx);
            t_pool_result res;
            int unsigned  size;
            int unsigned  start;
            int unsigned  slot;
            int unsigned  i;
            bit           found;
            res   = '0;
            size  = buffers_in_use();
            found = 1'b0;
            if (act == nfbpa_pkg::ACT_ALLOC) begin
                start = (32'(next_fit_from) < size) ? 32'(next_fit_from) : 0;
                for (i = 0; i < size && !found; i++) begin
                    slot = start + i;
                    if (slot >= size) slot -= size;
                    if (!used_flag[slot]) begin
                        used_flag[slot]   = 1'b1;
                        next_fit_from     = slot[nfbpa_pkg::INDEX_W-1:0];
                        res.granted_index = slot[nfbpa_pkg::INDEX_W-1:0];
                        found             = 1'b1;
                    end
                end
                if (found) begin
                    res.ok = 1'b1;
                    allocs = allocs + 1'b1;
                end else begin
                    failures = failures + 1'b1;
                end
            end else begin
                if (32'(idx) < size) begin
                    used_flag[idx] = 1'b0;
                    res.ok         = 1'b1;
                end
                frees = frees + 1'b1;
            end
            res.alloc_count = allocs;
            res.free_count  = frees;
            res.error_count = failures;
            expected_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [nfbpa_pkg::COUNT_W-1:0] exp_v,
                                    logic [nfbpa_pkg::COUNT_W-1:0] act_v);
            if (exp_v !== act_v) begin
                mismatches++;
                $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(t_pool_result got);
            t_pool_result exp_r;
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t: result with no request pending, expected none actual %h",
                         $time, got);
                return;
            end
            exp_r = expected_results.pop_front();
            compare_field("ok", nfbpa_pkg::COUNT_W'(exp_r.ok),
                          nfbpa_pkg::COUNT_W'(got.ok));
            compare_field("granted_index", nfbpa_pkg::COUNT_W'(exp_r.granted_index),
                          nfbpa_pkg::COUNT_W'(got.granted_index));
            compare_field("alloc_count", exp_r.alloc_count, got.alloc_count);
            compare_field("free_count", exp_r.free_count, got.free_count);
            compare_field("error_count", exp_r.error_count, got.error_count);
        endfunction
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [nfbpa_pkg::POOL_W-1:0] i_cfg_wdata;

    nfbpa_req_if req_if ();
    nfbpa_rsp_if rsp_if ();

    next_fit_buffer_pool_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    t_pool_tracker tracker = new();

    int sender_idle_pct   = 22;
    int receiver_idle_pct = 49;
    int hold_off_cycles   = 0;
    int alloc_requests    = 0;
    int free_requests     = 0;
    int pool_writes       = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles > 0) begin
                rsp_if.ready <= 1'b0;
                hold_off_cycles--;
            end else begin
                rsp_if.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
            end
        end
    end

    // Handshakes are sampled at the falling edge, where every signal is stable.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                tracker.take_request(nfbpa_pkg::t_action'(req_if.action),
                                     req_if.buffer_index);
                if (nfbpa_pkg::t_action'(req_if.action) == nfbpa_pkg::ACT_ALLOC)
                    alloc_requests++;
                else
                    free_requests++;
            end
            if (rsp_if.valid && rsp_if.ready) begin
                tracker.check_result({rsp_if.ok, rsp_if.granted_index, rsp_if.alloc_count,
                                      rsp_if.free_count, rsp_if.error_count});
            end
        end
    end

    task automatic issue_request(input nfbpa_pkg::t_action act,
                                 input logic [nfbpa_pkg::INDEX_W-1:0] idx);
        bit taken;
        req_if.valid        <= 1'b1;
        req_if.action       <= act;
        req_if.buffer_index <= idx;
        do begin
            @(negedge i_clk);
            taken = req_if.ready;
            @(posedge i_clk);
        end while (!taken);
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            req_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < sender_idle_pct);
        end
    endtask

    // The last accepted request is noted at the falling edge before the rising
    // edge that takes it, so its expected result is queued before the wait starts.
    task automatic drain_results();
        if (req_if.valid) req_if.valid <= 1'b0;
        @(posedge i_clk);
        @(negedge i_clk);
        while (tracker.expected_results.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_pool_size(input logic [nfbpa_pkg::POOL_W-1:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_pool_size(value);
        pool_writes++;
    endtask

    initial begin
        logic [nfbpa_pkg::POOL_W-1:0]  pool_value;
        int                            alloc_bias;
        int                            block_items;
        int unsigned                   size_now;
        logic [nfbpa_pkg::INDEX_W-1:0] idx;

        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_wdata         <= '0;
        req_if.valid        <= 1'b0;
        req_if.action       <= nfbpa_pkg::ACT_ALLOC;
        req_if.buffer_index <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue_request(nfbpa_pkg::ACT_ALLOC, 6'd0);
        issue_request(nfbpa_pkg::ACT_ALLOC, 6'd63);
        issue_request(nfbpa_pkg::ACT_ALLOC, 6'd0);
        issue_request(nfbpa_pkg::ACT_FREE, 6'd1);
        issue_request(nfbpa_pkg::ACT_FREE, 6'd1);
        issue_request(nfbpa_pkg::ACT_FREE, 6'd63);
        issue_request(nfbpa_pkg::ACT_ALLOC, 6'd0);
        issue_request(nfbpa_pkg::ACT_ALLOC, 6'd0);
        write_pool_size(7'd4);
        issue_request(nfbpa_pkg::ACT_ALLOC, 6'd0);
        issue_request(nfbpa_pkg::ACT_ALLOC, 6'd0);
        issue_request(nfbpa_pkg::ACT_FREE, 6'd5);
        issue_request(nfbpa_pkg::ACT_FREE, 6'd63);
        issue_request(nfbpa_pkg::ACT_FREE, 6'd2);
        issue_request(nfbpa_pkg::ACT_ALLOC, 6'd0);
        write_pool_size(7'd0);
        issue_request(nfbpa_pkg::ACT_ALLOC, 6'd0);
        issue_request(nfbpa_pkg::ACT_FREE, 6'd0);
        write_pool_size(7'd127);
        issue_request(nfbpa_pkg::ACT_ALLOC, 6'd0);
        issue_request(nfbpa_pkg::ACT_FREE, 6'd0);
        issue_request(nfbpa_pkg::ACT_ALLOC, 6'd0);

        for (int blk = 0; blk < 10; blk++) begin
            block_items = 58;
            case (blk)
                0: begin pool_value = 7'd64;  alloc_bias = 70; end
                1: begin pool_value = 7'd1;   alloc_bias = 50; end
                2: begin pool_value = 7'd2;   alloc_bias = 55; end
                3: begin pool_value = 7'd7;   alloc_bias = 65; end
                4: begin pool_value = 7'd0;   alloc_bias = 50; block_items = 15; end
                5: begin pool_value = 7'd100; alloc_bias = 75; end
                6: begin pool_value = 7'd127; alloc_bias = 40; end
                7: begin pool_value = 7'd33;  alloc_bias = 60; end
                8: begin pool_value = 7'd16;  alloc_bias = 50; end
                default: begin pool_value = 7'd64; alloc_bias = 45; end
            endcase
            write_pool_size(pool_value);
            if (blk == 4) begin
                sender_idle_pct   = 49;
                receiver_idle_pct = 22;
            end else if (blk == 7) begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            if (blk == 5) hold_off_cycles = 300;
            size_now = tracker.buffers_in_use();
            for (int n = 0; n < block_items; n++) begin
                if (blk == 8 && n == 29) drain_results();
                if ($urandom_range(0, 99) < alloc_bias) begin
                    issue_request(nfbpa_pkg::ACT_ALLOC, 6'($urandom_range(0, 63)));
                end else begin
                    if (size_now != 0 && $urandom_range(0, 99) < 85)
                        idx = 6'($urandom_range(0, size_now - 1));
                    else
                        idx = 6'($urandom_range(0, 63));
                    issue_request(nfbpa_pkg::ACT_FREE, idx);
                end
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        $display("Run covered %0d allocate and %0d free requests, %0d results checked,",
                 alloc_requests, free_requests, tracker.results_seen);
        $display("over %0d pool size writes including sizes 0, 1, 64 and above 64.",
                 pool_writes);
        if (tracker.mismatches == 0 && tracker.expected_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
